FILE: src/eaus_pkg.sv
// Shared types, constants and helpers for the encoder angle unwrap and speed block.
package eaus_pkg;

   // Field widths
   localparam int ANGLE_W   = 12;
   localparam int CENTI_W   = 16;
   localparam int POS_W     = 32;
   localparam int REV_W     = 20;
   localparam int SPEED_W   = 26;
   localparam int TIME_W    = 32;
   localparam int DELTA_W   = 13;
   localparam int ROT_SHIFT = 12;

   // Turn geometry in raw counts
   localparam int HALF_TURN = 2048;
   localparam int FULL_TURN = 4096;

   // Scaling: centidegrees per count is 879/100, speed numerator scale is 8790
   localparam int CENTI_SCALE = 879;
   localparam int SPEED_SCALE = 8790;
   localparam int CPROD_W     = 22;
   localparam int RECIP_SHIFT = 29;
   localparam int RECIP_W     = 23;
   localparam int unsigned RECIP_100 = ((32'd1 << RECIP_SHIFT) + 32'd99) / 32'd100;
   localparam int CSCALE_W    = CPROD_W + RECIP_W;
   localparam int MAX_CENTI   = ((FULL_TURN - 1) * CENTI_SCALE) / 100;

   // Divider: the dividend is at most HALF_TURN * SPEED_SCALE, which fits 25 bits
   localparam int NUM_W  = 25;
   localparam int DCNT_W = 5;

   // Default depth of the queue between front and back
   localparam int QUEUE_DEPTH_DEF = 2;

   // Request kinds
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_LOAD   = 1'b1;

   // Work word handed from front to back
   typedef struct packed {
      logic [ANGLE_W-1:0] angle;
      logic [POS_W-1:0]   position;
      logic [ANGLE_W-1:0] mag;
      logic               neg;
      logic [TIME_W-1:0]  dt;
      logic               div_en;
      logic               fresh;
   } work_type;

   // Back end sequencer states
   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL,
      BK_SCALE,
      BK_DIV,
      BK_DONE
   } back_state_type;

   // Angle difference v - r wrapped into [-HALF_TURN, HALF_TURN]
   function automatic logic signed [DELTA_W-1:0] wrap_delta(
      input logic [ANGLE_W-1:0] v,
      input logic [ANGLE_W-1:0] r
   );
      logic signed [DELTA_W:0] d;
      d = $signed({2'b00, v}) - $signed({2'b00, r});
      if (d > (DELTA_W+1)'(HALF_TURN)) begin
         d = d - (DELTA_W+1)'(FULL_TURN);
      end else if (d < -(DELTA_W+1)'(HALF_TURN)) begin
         d = d + (DELTA_W+1)'(FULL_TURN);
      end
      return d[DELTA_W-1:0];
   endfunction

endpackage

FILE: src/eaus_front.sv
// Front end: offset register, angle unwrap and speed state, builds one work word per request.
module eaus_front import eaus_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   // offset register write
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [ANGLE_W-1:0]  csr_angle_offset,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_kind,
   input  logic [ANGLE_W-1:0]  req_angle_raw,
   input  logic                req_read_error,
   input  logic [TIME_W-1:0]   req_time_ms,
   input  logic signed [POS_W-1:0] req_new_position,
   // queue side
   input  logic                q_full,
   output logic                q_push,
   output work_type            q_word
);

   logic [ANGLE_W-1:0] offset_ff, offset_in;
   logic [ANGLE_W-1:0] lga_ff, lga_in;
   logic [ANGLE_W-1:0] uref_ff, uref_in;
   logic [POS_W-1:0]   cum_ff, cum_in;
   logic [ANGLE_W-1:0] sref_ff, sref_in;
   logic [TIME_W-1:0]  tlast_ff, tlast_in;

   logic [ANGLE_W-1:0]        angle_new;
   logic [ANGLE_W-1:0]        angle_use;
   logic signed [DELTA_W-1:0] unwrap_d;
   logic signed [DELTA_W-1:0] speed_d;
   logic [TIME_W-1:0]         dt;

   // Accept whenever the queue has room
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;
   assign csr_ready = 1'b1;

   // Offset-corrected angle, wrapped to one turn
   assign angle_new = req_angle_raw + offset_ff;
   assign angle_use = req_read_error ? lga_ff : angle_new;
   assign unwrap_d  = wrap_delta(angle_new, uref_ff);
   assign speed_d   = wrap_delta(angle_new, sref_ff);
   assign dt        = req_time_ms - tlast_ff;

   // Next state and work word
   always_comb begin
      offset_in = csr_valid ? csr_angle_offset : offset_ff;
      lga_in    = lga_ff;
      uref_in   = uref_ff;
      cum_in    = cum_ff;
      sref_in   = sref_ff;
      tlast_in  = tlast_ff;

      q_word.angle    = angle_use;
      q_word.position = cum_ff;
      q_word.mag      = '0;
      q_word.neg      = 1'b0;
      q_word.dt       = dt;
      q_word.div_en   = 1'b0;
      q_word.fresh    = !req_read_error;

      if (q_push) begin
         if (!req_read_error) begin
            lga_in = angle_new;
         end
         if (req_kind == KIND_LOAD) begin
            uref_in = angle_use;
            cum_in  = req_new_position;
         end else if (!req_read_error) begin
            uref_in  = angle_new;
            cum_in   = cum_ff + {{(POS_W-DELTA_W){unwrap_d[DELTA_W-1]}}, unwrap_d};
            sref_in  = angle_new;
            tlast_in = req_time_ms;
         end
      end

      // Sample with a good reading: report new position, set up the divide
      if (req_kind == KIND_SAMPLE && !req_read_error) begin
         q_word.position = cum_ff + {{(POS_W-DELTA_W){unwrap_d[DELTA_W-1]}}, unwrap_d};
         q_word.neg      = speed_d[DELTA_W-1];
         q_word.mag      = speed_d[DELTA_W-1] ? ANGLE_W'(-speed_d) : speed_d[ANGLE_W-1:0];
         q_word.div_en   = (dt != '0);
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         lga_ff    <= '0;
         uref_ff   <= '0;
         cum_ff    <= '0;
         sref_ff   <= '0;
         tlast_ff  <= '0;
      end else begin
         offset_ff <= offset_in;
         lga_ff    <= lga_in;
         uref_ff   <= uref_in;
         cum_ff    <= cum_in;
         sref_ff   <= sref_in;
         tlast_ff  <= tlast_in;
      end
   end

endmodule

FILE: src/eaus_queue.sv
// Short work queue between front and back.
module eaus_queue import eaus_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  work_type push_word,
   output logic     full,
   input  logic     pop,
   output logic     not_empty,
   output work_type head_word
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   work_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_word = mem_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed word
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

FILE: src/eaus_back.sv
// Back end: centidegree scaling, serial speed divide and the result register.
module eaus_back import eaus_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   // queue side
   input  logic                      q_not_empty,
   input  work_type                  q_head,
   output logic                      q_pop,
   // result channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [ANGLE_W-1:0]        rsp_angle,
   output logic [CENTI_W-1:0]        rsp_angle_centideg,
   output logic signed [POS_W-1:0]   rsp_position,
   output logic signed [REV_W-1:0]   rsp_revolutions,
   output logic signed [SPEED_W-1:0] rsp_speed,
   output logic                      rsp_fresh
);

   back_state_type state_ff, state_in;

   work_type             work_ff, work_in;
   logic [NUM_W-1:0]     num_ff, num_in;
   logic [CPROD_W-1:0]   cprod_ff, cprod_in;
   logic [CENTI_W-1:0]   centi_ff, centi_in;
   logic [TIME_W-1:0]    rem_ff, rem_in;
   logic [NUM_W-1:0]     quo_ff, quo_in;
   logic [DCNT_W-1:0]    cnt_ff, cnt_in;

   logic                 out_valid_ff, out_valid_in;
   logic [ANGLE_W-1:0]   out_angle_ff, out_angle_in;
   logic [CENTI_W-1:0]   out_centi_ff, out_centi_in;
   logic [POS_W-1:0]     out_pos_ff, out_pos_in;
   logic [REV_W-1:0]     out_rev_ff, out_rev_in;
   logic [SPEED_W-1:0]   out_speed_ff, out_speed_in;
   logic                 out_fresh_ff, out_fresh_in;

   logic                 ld_work, ld_mul, ld_scale, div_step, out_load, div_last;
   logic                 out_free;
   logic [TIME_W:0]      trial;
   logic                 trial_ge;
   logic [SPEED_W-1:0]   num_prod;
   logic [CSCALE_W-1:0]  cscale;
   logic [SPEED_W-1:0]   speed_val;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign div_last = (cnt_ff == DCNT_W'(NUM_W - 1));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE:  if (q_not_empty) state_in = BK_MUL;
         BK_MUL:   state_in = BK_SCALE;
         BK_SCALE: state_in = work_ff.div_en ? BK_DIV : BK_DONE;
         BK_DIV:   if (div_last) state_in = BK_DONE;
         BK_DONE:  if (out_free) state_in = BK_IDLE;
         default:  state_in = BK_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      ld_work  = 1'b0;
      ld_mul   = 1'b0;
      ld_scale = 1'b0;
      div_step = 1'b0;
      out_load = 1'b0;
      case (state_ff)
         BK_IDLE:  ld_work  = q_not_empty;
         BK_MUL:   ld_mul   = 1'b1;
         BK_SCALE: ld_scale = 1'b1;
         BK_DIV:   div_step = 1'b1;
         BK_DONE:  out_load = out_free;
         default:  ld_work  = 1'b0;
      endcase
   end

   assign q_pop = ld_work;

   // Datapath
   assign num_prod  = SPEED_W'(work_ff.mag) * SPEED_W'(SPEED_SCALE);
   assign cscale    = CSCALE_W'(cprod_ff) * CSCALE_W'(RECIP_100);
   assign trial     = {rem_ff, quo_ff[NUM_W-1]};
   assign trial_ge  = (trial >= {1'b0, work_ff.dt});
   assign speed_val = !work_ff.div_en ? '0 :
                      work_ff.neg ? SPEED_W'(-{1'b0, quo_ff}) : SPEED_W'(quo_ff);

   always_comb begin
      work_in  = ld_work ? q_head : work_ff;
      num_in   = num_ff;
      cprod_in = cprod_ff;
      centi_in = centi_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      // multiply stage
      if (ld_mul) begin
         num_in   = num_prod[NUM_W-1:0];
         cprod_in = CPROD_W'(work_ff.angle) * CPROD_W'(CENTI_SCALE);
      end
      // divide by 100 via reciprocal; set up divider
      if (ld_scale) begin
         centi_in = cscale[RECIP_SHIFT +: CENTI_W];
         rem_in   = '0;
         quo_in   = num_ff;
         cnt_in   = '0;
      end
      // one restoring divide step a cycle
      if (div_step) begin
         rem_in = trial_ge ? TIME_W'(trial - {1'b0, work_ff.dt}) : trial[TIME_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], trial_ge};
         cnt_in = cnt_ff + 1'b1;
      end
   end

   // Result register: hold while stalled
   always_comb begin
      out_valid_in = out_valid_ff;
      out_angle_in = out_angle_ff;
      out_centi_in = out_centi_ff;
      out_pos_in   = out_pos_ff;
      out_rev_in   = out_rev_ff;
      out_speed_in = out_speed_ff;
      out_fresh_in = out_fresh_ff;
      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
      if (out_load) begin
         out_valid_in = 1'b1;
         out_angle_in = work_ff.angle;
         out_centi_in = centi_ff;
         out_pos_in   = work_ff.position;
         out_rev_in   = work_ff.position[POS_W-1:ROT_SHIFT]
                        + {{(REV_W-1){1'b0}}, work_ff.position[POS_W-1]};
         out_speed_in = speed_val;
         out_fresh_in = work_ff.fresh;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff      <= work_in;
      num_ff       <= num_in;
      cprod_ff     <= cprod_in;
      centi_ff     <= centi_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      cnt_ff       <= cnt_in;
      out_angle_ff <= out_angle_in;
      out_centi_ff <= out_centi_in;
      out_pos_ff   <= out_pos_in;
      out_rev_ff   <= out_rev_in;
      out_speed_ff <= out_speed_in;
      out_fresh_ff <= out_fresh_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_angle          = out_angle_ff;
   assign rsp_angle_centideg = out_centi_ff;
   assign rsp_position       = out_pos_ff;
   assign rsp_revolutions    = out_rev_ff;
   assign rsp_speed          = out_speed_ff;
   assign rsp_fresh          = out_fresh_ff;

endmodule

FILE: src/encoder_angle_unwrap_speed.sv
// Top level of the encoder angle unwrap and speed block.
//
//   Port group | Direction | Handshake         | Carries
//   req_*      | in        | valid / stall     | kind, raw angle, error flag, time, new position
//   rsp_*      | out       | valid / stall     | angle, centidegrees, position, revolutions, speed
//   csr_*      | in        | valid / ready     | angle offset
//
// The front takes one request word per cycle while the work queue has room and updates
// the unwrap and speed state in that same cycle. The back takes one word at a time through
// multiply, scale and done; a sample with a nonzero interval also runs the 25-step restoring
// divider. Synchronous reset zeroes the front state and offset, empties the queue, idles the
// back. A stalled result holds in the output register while the back finishes the next word.
module encoder_angle_unwrap_speed import eaus_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [ANGLE_W-1:0]        csr_angle_offset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_kind,
   input  logic [ANGLE_W-1:0]        req_angle_raw,
   input  logic                      req_read_error,
   input  logic [TIME_W-1:0]         req_time_ms,
   input  logic signed [POS_W-1:0]   req_new_position,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [ANGLE_W-1:0]        rsp_angle,
   output logic [CENTI_W-1:0]        rsp_angle_centideg,
   output logic signed [POS_W-1:0]   rsp_position,
   output logic signed [REV_W-1:0]   rsp_revolutions,
   output logic signed [SPEED_W-1:0] rsp_speed,
   output logic                      rsp_fresh
);

   logic     q_push, q_full, q_pop, q_not_empty;
   work_type q_word, q_head;

   eaus_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_angle_offset (csr_angle_offset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_angle_raw    (req_angle_raw),
      .req_read_error   (req_read_error),
      .req_time_ms      (req_time_ms),
      .req_new_position (req_new_position),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_word           (q_word)
   );

   eaus_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_word (q_word),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_word (q_head)
   );

   eaus_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_not_empty        (q_not_empty),
      .q_head             (q_head),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_angle          (rsp_angle),
      .rsp_angle_centideg (rsp_angle_centideg),
      .rsp_position       (rsp_position),
      .rsp_revolutions    (rsp_revolutions),
      .rsp_speed          (rsp_speed),
      .rsp_fresh          (rsp_fresh)
   );

   // A failed reading never reports motion
   a_stale_no_speed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_fresh |-> rsp_speed == '0)
      else $error("speed nonzero on a stale word");

   // Scaled angle stays within one turn
   a_centi_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_angle_centideg <= CENTI_W'(MAX_CENTI))
      else $error("centidegree value out of range");

   // Nonnegative position: revolutions are the upper position bits
   a_rev_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_position[POS_W-1] |->
         rsp_revolutions == rsp_position[POS_W-1:ROT_SHIFT])
      else $error("revolutions disagree with position");

   // The back only takes a word that the queue holds
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_not_empty)
      else $error("queue read while empty");

endmodule

FILE: bench/encoder_angle_unwrap_speed_tb.sv
// Self-checking testbench for the encoder angle unwrap and speed block.
module encoder_angle_unwrap_speed_tb;
   import eaus_pkg::*;

   localparam int QUIET_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 40;
   localparam int REPORT_MAX   = 10;

   // One request word as the sender presents it
   typedef struct {
      logic               kind;
      logic [ANGLE_W-1:0] raw;
      logic               err;
      logic [TIME_W-1:0]  stamp;
      logic [POS_W-1:0]   load_pos;
   } request_word_type;

   // One expected result word
   typedef struct {
      logic [ANGLE_W-1:0]        angle;
      logic [CENTI_W-1:0]        centideg;
      logic signed [POS_W-1:0]   position;
      logic signed [REV_W-1:0]   revs;
      logic signed [SPEED_W-1:0] speed;
      logic                      fresh;
   } reading_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [ANGLE_W-1:0]        csr_angle_offset = '0;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_kind = KIND_SAMPLE;
   logic [ANGLE_W-1:0]        req_angle_raw = '0;
   logic                      req_read_error = 1'b0;
   logic [TIME_W-1:0]         req_time_ms = '0;
   logic signed [POS_W-1:0]   req_new_position = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [ANGLE_W-1:0]        rsp_angle;
   logic [CENTI_W-1:0]        rsp_angle_centideg;
   logic signed [POS_W-1:0]   rsp_position;
   logic signed [REV_W-1:0]   rsp_revolutions;
   logic signed [SPEED_W-1:0] rsp_speed;
   logic                      rsp_fresh;

   // Words waiting to be sent and results still owed by the block
   request_word_type request_words[$];
   reading_type      predicted_readings[$];
   request_word_type in_flight;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int failure_count  = 0;
   int result_count   = 0;
   int quiet_cycles   = 0;

   // Tracked copy of the block's state
   logic [ANGLE_W-1:0] offset_q     = '0;
   logic [ANGLE_W-1:0] good_angle   = '0;
   logic [ANGLE_W-1:0] unwrap_ref   = '0;
   logic [ANGLE_W-1:0] speed_ref    = '0;
   logic [POS_W-1:0]   position_acc = '0;
   logic [TIME_W-1:0]  last_stamp   = '0;

   // Random walk state for well-formed sample streams
   logic [ANGLE_W-1:0] walk_raw   = '0;
   logic [TIME_W-1:0]  walk_stamp = '0;

   encoder_angle_unwrap_speed uut (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_angle_offset   (csr_angle_offset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_angle_raw      (req_angle_raw),
      .req_read_error     (req_read_error),
      .req_time_ms        (req_time_ms),
      .req_new_position   (req_new_position),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_angle          (rsp_angle),
      .rsp_angle_centideg (rsp_angle_centideg),
      .rsp_position       (rsp_position),
      .rsp_revolutions    (rsp_revolutions),
      .rsp_speed          (rsp_speed),
      .rsp_fresh          (rsp_fresh)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Fold an angle difference into the shorter way around the turn
   function automatic int fold_half_turn(int d);
      if (d > HALF_TURN) begin
         return d - FULL_TURN;
      end else if (d < -HALF_TURN) begin
         return d + FULL_TURN;
      end
      return d;
   endfunction

   // Advance the tracked state by one accepted word and return the result it owes
   function automatic reading_type track_encoder(request_word_type w);
      reading_type        r;
      int                 d;
      logic [TIME_W-1:0]  dt;
      logic [31:0]        mag_abs;
      logic [31:0]        mag;
      logic [POS_W-1:0]   pos;
      logic [31:0]        shifted;
      r.speed = '0;
      if (!w.err) begin
         good_angle = w.raw + offset_q;
      end
      if (w.kind == KIND_LOAD) begin
         unwrap_ref   = good_angle;
         pos          = position_acc;
         position_acc = w.load_pos;
      end else begin
         if (!w.err) begin
            d = fold_half_turn(int'(good_angle) - int'(unwrap_ref));
            position_acc = position_acc + d;
            unwrap_ref   = good_angle;
            d  = fold_half_turn(int'(good_angle) - int'(speed_ref));
            dt = w.stamp - last_stamp;
            last_stamp = w.stamp;
            speed_ref  = good_angle;
            if (dt != 0) begin
               mag_abs = (d < 0) ? -d : d;
               mag     = mag_abs * SPEED_SCALE / dt;
               r.speed = SPEED_W'((d < 0) ? -mag : mag);
            end
         end
         pos = position_acc;
      end
      r.angle    = good_angle;
      r.centideg = CENTI_W'((32'(good_angle) * CENTI_SCALE) / 100);
      r.position = pos;
      shifted    = 32'($signed(pos) >>> ROT_SHIFT);
      if (pos[POS_W-1]) begin
         shifted = shifted + 1;
      end
      r.revs  = shifted[REV_W-1:0];
      r.fresh = !w.err;
      return r;
   endfunction

   function automatic void note_failure(string what);
      failure_count++;
      if (failure_count <= REPORT_MAX) begin
         $display("mismatch at result %0d: %s", result_count, what);
      end
   endfunction

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         note_failure($sformatf("%s expected %0h got %0h", name, want, got));
      end
   endfunction

   task automatic push_word(logic kind, logic [ANGLE_W-1:0] raw, logic err,
                            logic [TIME_W-1:0] stamp, logic [POS_W-1:0] load_pos);
      request_word_type w;
      w.kind     = kind;
      w.raw      = raw;
      w.err      = err;
      w.stamp    = stamp;
      w.load_pos = load_pos;
      request_words.push_back(w);
   endtask

   // Write the offset register; only called while the block is drained
   task automatic write_offset(logic [ANGLE_W-1:0] value);
      @(posedge clock);
      csr_valid        <= 1'b1;
      csr_angle_offset <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      offset_q   = value;
   endtask

   // Hold until every queued word is sent and every result has come back
   task automatic wait_drained();
      do @(negedge clock);
      while (request_words.size() != 0 || req_valid || predicted_readings.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Mostly well-formed motion with random content, the rest loads and noise
   task automatic queue_random_words(int count);
      int                pick;
      int                step;
      logic [TIME_W-1:0] gap;
      logic [POS_W-1:0]  load_pos;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            if ($urandom_range(1) == 1) begin
               step = int'($urandom_range(600)) - 300;
            end else begin
               step = int'($urandom_range(4094)) - 2047;
            end
            walk_raw = walk_raw + ANGLE_W'(step);
            case ($urandom_range(19))
               0:       gap = '0;
               1:       gap = $urandom;
               default: gap = $urandom_range(1, 200);
            endcase
            walk_stamp = walk_stamp + gap;
            push_word(KIND_SAMPLE, walk_raw, $urandom_range(19) == 0, walk_stamp, $urandom);
         end else if (pick < 80) begin
            push_word(KIND_SAMPLE, ANGLE_W'($urandom), 1'b1, $urandom, $urandom);
         end else if (pick < 88) begin
            case ($urandom_range(7))
               0:       load_pos = 32'h7FFF_FFFF;
               1:       load_pos = 32'h8000_0000;
               2:       load_pos = 32'h0000_0000;
               3:       load_pos = 32'hFFFF_FFFF;
               default: load_pos = $urandom;
            endcase
            push_word(KIND_LOAD, ANGLE_W'($urandom), $urandom_range(3) == 0, $urandom,
                      load_pos);
         end else begin
            walk_raw   = ANGLE_W'($urandom);
            walk_stamp = $urandom;
            push_word(KIND_SAMPLE, walk_raw, 1'b0, walk_stamp, $urandom);
         end
      end
   endtask

   // Drive request words; predict each one at the edge it is accepted
   always @(posedge clock) begin
      request_word_type nxt;
      logic             hold;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predicted_readings.push_back(track_encoder(in_flight));
         end
         hold = req_valid && req_stall;
         if (!hold) begin
            if (request_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = request_words.pop_front();
               in_flight = nxt;
               req_valid        <= 1'b1;
               req_kind         <= nxt.kind;
               req_angle_raw    <= nxt.raw;
               req_read_error   <= nxt.err;
               req_time_ms      <= nxt.stamp;
               req_new_position <= nxt.load_pos;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Check each accepted result word against the oldest prediction
   always @(posedge clock) begin
      reading_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            result_count++;
            if (predicted_readings.size() == 0) begin
               note_failure($sformatf("unexpected word angle=%0h position=%0h",
                                      rsp_angle, rsp_position));
            end else begin
               want = predicted_readings.pop_front();
               compare_field("angle", 32'(want.angle), 32'(rsp_angle));
               compare_field("angle_centideg", 32'(want.centideg), 32'(rsp_angle_centideg));
               compare_field("position", 32'(want.position), 32'(rsp_position));
               compare_field("revolutions", 32'(want.revs), 32'(rsp_revolutions));
               compare_field("speed", 32'(want.speed), 32'(rsp_speed));
               compare_field("fresh", 32'(want.fresh), 32'(rsp_fresh));
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Count cycles in which no handshake completes
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      wait (!reset);
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      write_offset(12'd0);

      // Directed: extremes, errors, zero interval, loads, wraps of time and position
      push_word(KIND_SAMPLE, 12'd0,    1'b0, 32'd0, 32'h1234_5678);
      push_word(KIND_SAMPLE, 12'd4095, 1'b0, 32'd1, 32'hEDCB_A987);
      push_word(KIND_SAMPLE, 12'd2047, 1'b0, 32'd2, 32'h0);
      push_word(KIND_SAMPLE, 12'd4095, 1'b0, 32'd3, 32'hFFFF_FFFF);
      push_word(KIND_SAMPLE, 12'd100,  1'b1, 32'd4, 32'h0);
      push_word(KIND_SAMPLE, 12'd10,   1'b0, 32'd3, 32'h0);
      push_word(KIND_LOAD,   12'd0,    1'b0, 32'd9, 32'h7FFF_F800);
      push_word(KIND_SAMPLE, 12'd2000, 1'b0, 32'd20, 32'h0);
      push_word(KIND_SAMPLE, 12'd4000, 1'b0, 32'd25, 32'h0);
      push_word(KIND_SAMPLE, 12'd1904, 1'b0, 32'd30, 32'h0);
      push_word(KIND_LOAD,   12'd3000, 1'b1, 32'd31, 32'h8000_0000);
      push_word(KIND_LOAD,   12'd4095, 1'b0, 32'd32, 32'hFFFF_FFFF);
      push_word(KIND_SAMPLE, 12'd4095, 1'b0, 32'hFFFF_FFFE, 32'h0);
      push_word(KIND_SAMPLE, 12'd0,    1'b0, 32'd5, 32'h0);
      push_word(KIND_LOAD,   12'd4095, 1'b0, 32'd6, 32'h7FFF_FFFF);
      push_word(KIND_SAMPLE, 12'd0,    1'b0, 32'h8000_0006, 32'h0);
      push_word(KIND_SAMPLE, 12'd4000, 1'b0, 32'h8000_0007, 32'h0);
      push_word(KIND_SAMPLE, 12'd4095, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_word(KIND_LOAD,   12'd0,    1'b1, 32'd0, 32'h0);
      push_word(KIND_SAMPLE, 12'd2048, 1'b0, 32'h8000_0010, 32'h0);
      walk_raw   = 12'd2048;
      walk_stamp = 32'h8000_0010;
      wait_drained();

      // Random phases, each with its own offset and idling pattern
      write_offset(12'hFFF);
      queue_random_words(210);
      wait_drained();

      write_offset(ANGLE_W'($urandom_range(1, 4094)));
      send_idle_pct = 74;
      queue_random_words(210);
      wait_drained();

      write_offset(12'd2048);
      send_idle_pct  = 0;
      recv_stall_pct = 74;
      queue_random_words(210);
      wait_drained();

      write_offset(12'd1);
      send_idle_pct  = 17;
      recv_stall_pct = 17;
      queue_random_words(210);
      wait_drained();

      if (predicted_readings.size() != 0) begin
         note_failure($sformatf("%0d results never arrived", predicted_readings.size()));
      end
      if (failure_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
